// ----- src/swsd_pkg.sv -----
// ----------------------------------------------------------------------------
// swsd_pkg: shared types and constants for the stopwatch display
// Item kinds, the time-of-count record, segment patterns and reset values.
// ----------------------------------------------------------------------------
package swsd_pkg;

  localparam int WRAP_SECONDS_DEF = 43200;
  localparam int HOUR_W           = 5;
  localparam logic [7:0] THRESHOLD_RESET = 8'd100;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_PRESS  = 2'd1,
    KIND_ADJUST = 2'd2
  } kind_t;

  typedef logic [7:0] seg_t;

  // Count held as decimal digits so the display needs no division.
  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [2:0]        min_tens;
    logic [3:0]        min_ones;
    logic [2:0]        sec_tens;
    logic [3:0]        sec_ones;
  } time_t;

  typedef struct packed {
    time_t tm;
    logic  running;
    logic  colon;
  } status_t;

  localparam seg_t SEG_TABLE [10] = '{
    8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE0, 8'hFF, 8'hE7
  };

  function automatic seg_t seg_of(input logic [3:0] digit);
    seg_t pattern;
    pattern = 8'h00;
    if (digit <= 4'd9) begin
      pattern = SEG_TABLE[digit];
    end
    return pattern;
  endfunction

endpackage

// ----- src/swsd_if.sv -----
// ----------------------------------------------------------------------------
// swsd_if: item and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface swsd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] hold_count;
  logic       adjust_down;

  modport source (output valid, kind, hold_count, adjust_down, input ready);
  modport sink   (input valid, kind, hold_count, adjust_down, output ready);
endinterface

interface swsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] hour_tens_segments;
  logic [7:0] hour_ones_segments;
  logic [7:0] minute_tens_segments;
  logic [7:0] minute_ones_segments;
  logic [7:0] second_tens_segments;
  logic [7:0] second_ones_segments;
  logic       running_flag;
  logic       colon_lit;

  modport source (
    output valid, hour_tens_segments, hour_ones_segments, minute_tens_segments,
           minute_ones_segments, second_tens_segments, second_ones_segments,
           running_flag, colon_lit,
    input  ready
  );
  modport sink (
    input  valid, hour_tens_segments, hour_ones_segments, minute_tens_segments,
           minute_ones_segments, second_tens_segments, second_ones_segments,
           running_flag, colon_lit,
    output ready
  );
endinterface

// ----- src/swsd_clock.sv -----
// ----------------------------------------------------------------------------
// swsd_clock: stopwatch state and its per-beat update
// Holds the digit count, run flag and colon flag; gives the state after a beat.
// ----------------------------------------------------------------------------
module swsd_clock #(
  parameter int WRAP_SECONDS = swsd_pkg::WRAP_SECONDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        kind,
  input  logic [7:0]        hold_count,
  input  logic              adjust_down,
  input  logic [7:0]        threshold,
  output swsd_pkg::status_t status_next
);
  import swsd_pkg::*;

  localparam int LAST    = WRAP_SECONDS - 1;
  localparam int LAST_H  = LAST / 3600;
  localparam int LAST_MT = (LAST % 3600) / 600;
  localparam int LAST_MO = (LAST % 600) / 60;
  localparam int LAST_ST = (LAST % 60) / 10;
  localparam int LAST_SO = LAST % 10;
  localparam time_t TIME_LAST = '{
    HOUR_W'(LAST_H), 3'(LAST_MT), 4'(LAST_MO), 3'(LAST_ST), 4'(LAST_SO)
  };

  status_t cur;
  time_t   t_up;
  time_t   t_down;

  // Count up one second, carry through the digits, wrap at the last value.
  always_comb begin
    t_up = cur.tm;
    if (cur.tm == TIME_LAST) begin
      t_up = '0;
    end else if (cur.tm.sec_ones != 4'd9) begin
      t_up.sec_ones = cur.tm.sec_ones + 4'd1;
    end else begin
      t_up.sec_ones = 4'd0;
      if (cur.tm.sec_tens != 3'd5) begin
        t_up.sec_tens = cur.tm.sec_tens + 3'd1;
      end else begin
        t_up.sec_tens = 3'd0;
        if (cur.tm.min_ones != 4'd9) begin
          t_up.min_ones = cur.tm.min_ones + 4'd1;
        end else begin
          t_up.min_ones = 4'd0;
          if (cur.tm.min_tens != 3'd5) begin
            t_up.min_tens = cur.tm.min_tens + 3'd1;
          end else begin
            t_up.min_tens = 3'd0;
            t_up.hours    = cur.tm.hours + HOUR_W'(1);
          end
        end
      end
    end
  end

  // Count down one second, borrow through the digits, wrap below zero.
  always_comb begin
    t_down = cur.tm;
    if (cur.tm == '0) begin
      t_down = TIME_LAST;
    end else if (cur.tm.sec_ones != 4'd0) begin
      t_down.sec_ones = cur.tm.sec_ones - 4'd1;
    end else begin
      t_down.sec_ones = 4'd9;
      if (cur.tm.sec_tens != 3'd0) begin
        t_down.sec_tens = cur.tm.sec_tens - 3'd1;
      end else begin
        t_down.sec_tens = 3'd5;
        if (cur.tm.min_ones != 4'd0) begin
          t_down.min_ones = cur.tm.min_ones - 4'd1;
        end else begin
          t_down.min_ones = 4'd9;
          if (cur.tm.min_tens != 3'd0) begin
            t_down.min_tens = cur.tm.min_tens - 3'd1;
          end else begin
            t_down.min_tens = 3'd5;
            t_down.hours    = cur.tm.hours - HOUR_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    status_next       = cur;
    status_next.colon = ~cur.colon;
    case (kind)
      KIND_TICK: begin
        if (cur.running) begin
          status_next.tm = t_up;
        end
      end
      KIND_PRESS: begin
        if (hold_count > threshold) begin
          status_next.running = 1'b0;
          status_next.tm      = '0;
        end else begin
          status_next.running = ~cur.running;
        end
      end
      KIND_ADJUST: begin
        status_next.tm = adjust_down ? t_down : t_up;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.tm      <= '0;
      cur.running <= 1'b1;
      cur.colon   <= 1'b0;
    end else if (step) begin
      cur <= status_next;
    end
  end

  a_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    cur.tm.sec_ones <= 4'd9 && cur.tm.sec_tens <= 3'd5 &&
    cur.tm.min_ones <= 4'd9 && cur.tm.min_tens <= 3'd5 &&
    int'(cur.tm.hours) <= LAST_H)
    else $error("stopwatch digit out of range");

  a_colon_toggles: assert property (@(posedge clk) disable iff (rst)
    step |=> cur.colon != $past(cur.colon))
    else $error("colon did not toggle on a beat");

  a_long_press_clears: assert property (@(posedge clk) disable iff (rst)
    step && kind == KIND_PRESS && hold_count > threshold |=>
      !cur.running && cur.tm == '0)
    else $error("long press did not pause and clear");

endmodule

// ----- src/stopwatch_seven_segment_display.sv -----
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_display: 12-hour stopwatch with digit decode
// Ticks, button presses and adjust steps update an HH:MM:SS count; each
// item returns six seven-segment patterns, the run flag and the colon flag.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | beat
//  ---------+-----+-------------------------------------------+---------------
//  item     | in  | kind, hold_count, adjust_down             | valid & ready
//  result   | out | six segment patterns, running_flag, colon | valid & ready
//  cfg      | in  | cfg_wdata -> long-press threshold         | cfg_we high
//
//  One item per cycle sustained while result.ready stays high; an item passes
//  the input register, then the result register.
//  The state update and digit decode sit in one stage between those registers.
//  A full result register with result.ready low holds the input stage; the
//  input stage still takes a beat while it is empty.
//  Synchronous reset: count 00:00:00, running, colon off, threshold 100.
// ----------------------------------------------------------------------------
module stopwatch_seven_segment_display #(
  parameter int WRAP_SECONDS = swsd_pkg::WRAP_SECONDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  swsd_item_if.sink     item,
  swsd_result_if.source result
);
  import swsd_pkg::*;

  // Long-press threshold; the user writes it only while idle, not enforced here.
  logic [7:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Input register.
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_hold;
  logic       s1_down;
  logic       s1_adv;
  logic       out_valid;

  // Advance the input stage whenever the result register is free or drains.
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind <= item.kind;
      s1_hold <= item.hold_count;
      s1_down <= item.adjust_down;
    end
  end

  // State update: the clock register commits as the item leaves stage 1.
  status_t st_next;

  swsd_clock #(
    .WRAP_SECONDS(WRAP_SECONDS)
  ) u_clock (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .kind        (s1_kind),
    .hold_count  (s1_hold),
    .adjust_down (s1_down),
    .threshold   (threshold),
    .status_next (st_next)
  );

  // Split the binary hour (0..11 at the default wrap) into two decimal digits.
  logic [3:0] hour_tens;
  logic [3:0] hour_ones;

  always_comb begin
    if (st_next.tm.hours >= HOUR_W'(20)) begin
      hour_tens = 4'd2;
      hour_ones = 4'(st_next.tm.hours - HOUR_W'(20));
    end else if (st_next.tm.hours >= HOUR_W'(10)) begin
      hour_tens = 4'd1;
      hour_ones = 4'(st_next.tm.hours - HOUR_W'(10));
    end else begin
      hour_tens = 4'd0;
      hour_ones = 4'(st_next.tm.hours);
    end
  end

  // Result register: hold while the sink stalls, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.hour_tens_segments   <= seg_of(hour_tens);
      result.hour_ones_segments   <= seg_of(hour_ones);
      result.minute_tens_segments <= seg_of({1'b0, st_next.tm.min_tens});
      result.minute_ones_segments <= seg_of(st_next.tm.min_ones);
      result.second_tens_segments <= seg_of({1'b0, st_next.tm.sec_tens});
      result.second_ones_segments <= seg_of(st_next.tm.sec_ones);
      result.running_flag         <= st_next.running;
      result.colon_lit            <= st_next.colon;
    end
  end

  assign result.valid = out_valid;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> item.ready)
    else $error("item channel stalled with an empty result register");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !s1_adv)
    else $error("pending result overwritten");

endmodule

// ----- verif/stopwatch_display_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_display_checker: scoreboard for the stopwatch display
// Tracks the count, run flag, colon and long-press threshold from item beats
// and register writes, and compares each result beat with the oldest display.
// ----------------------------------------------------------------------------
module stopwatch_display_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  swsd_item_if       item,
  swsd_result_if     result,
  output int         mismatches,
  output int         pending
);

  localparam int unsigned WRAP_SEC = swsd_pkg::WRAP_SECONDS_DEF;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int REPORT_LIMIT = 10;

  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE0, 8'hFF, 8'hE7
  };

  typedef struct packed {
    logic [7:0] hour_tens;
    logic [7:0] hour_ones;
    logic [7:0] min_tens;
    logic [7:0] min_ones;
    logic [7:0] sec_tens;
    logic [7:0] sec_ones;
    logic       running;
    logic       colon;
  } display_t;

  int unsigned count_sec;
  logic        run_now;
  logic        colon_now;
  logic [7:0]  threshold;
  display_t    pending_displays[$];
  int          results_seen;

  // One-second step with wrap in both directions.
  function automatic int unsigned stepped(input int unsigned sec, input logic down);
    if (down) begin
      return (sec == 0) ? WRAP_SEC - 1 : sec - 1;
    end
    return (sec + 1 >= WRAP_SEC) ? 0 : sec + 1;
  endfunction

  // Apply one item to the watch and return the display that follows it.
  function automatic display_t predict_display(input logic [1:0] kind,
                                               input logic [7:0] hold,
                                               input logic down);
    display_t    d;
    int unsigned hr, mn, sc;
    case (kind)
      swsd_pkg::KIND_TICK: begin
        if (run_now) count_sec = stepped(count_sec, 1'b0);
      end
      swsd_pkg::KIND_PRESS: begin
        if (hold > threshold) begin
          run_now   = 1'b0;
          count_sec = 0;
        end else begin
          run_now = ~run_now;
        end
      end
      swsd_pkg::KIND_ADJUST: begin
        count_sec = stepped(count_sec, down);
      end
      default: begin
        // spare code: count and run flag stay, colon still blinks
      end
    endcase
    colon_now = ~colon_now;
    sc = count_sec % SEC_PER_MIN;
    mn = (count_sec % SEC_PER_HOUR) / SEC_PER_MIN;
    hr = (count_sec / SEC_PER_HOUR) % 100;
    d.hour_tens = DIGIT_SEGMENTS[hr / 10];
    d.hour_ones = DIGIT_SEGMENTS[hr % 10];
    d.min_tens  = DIGIT_SEGMENTS[mn / 10];
    d.min_ones  = DIGIT_SEGMENTS[mn % 10];
    d.sec_tens  = DIGIT_SEGMENTS[sc / 10];
    d.sec_ones  = DIGIT_SEGMENTS[sc % 10];
    d.running   = run_now;
    d.colon     = colon_now;
    return d;
  endfunction

  function automatic string show(input display_t d);
    return $sformatf("segs %h %h:%h %h:%h %h run %b colon %b", d.hour_tens, d.hour_ones,
                     d.min_tens, d.min_ones, d.sec_tens, d.sec_ones, d.running, d.colon);
  endfunction

  always @(posedge clk) begin
    display_t want, got;
    logic     bad;
    if (rst) begin
      count_sec    = 0;
      run_now      = 1'b1;
      colon_now    = 1'b0;
      threshold    = swsd_pkg::THRESHOLD_RESET;
      results_seen = 0;
      mismatches   = 0;
      pending_displays.delete();
    end else begin
      if (cfg_we) threshold = cfg_wdata;
      if (result.valid && result.ready) begin
        got.hour_tens = result.hour_tens_segments;
        got.hour_ones = result.hour_ones_segments;
        got.min_tens  = result.minute_tens_segments;
        got.min_ones  = result.minute_ones_segments;
        got.sec_tens  = result.second_tens_segments;
        got.sec_ones  = result.second_ones_segments;
        got.running   = result.running_flag;
        got.colon     = result.colon_lit;
        if (pending_displays.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d: none expected, got %s", results_seen, show(got));
        end else begin
          want = pending_displays.pop_front();
          bad = (got.hour_tens !== want.hour_tens) || (got.hour_ones !== want.hour_ones) ||
                (got.min_tens !== want.min_tens) || (got.min_ones !== want.min_ones) ||
                (got.sec_tens !== want.sec_tens) || (got.sec_ones !== want.sec_ones) ||
                (got.running !== want.running) || (got.colon !== want.colon);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d: expected %s, actual %s", results_seen, show(want),
                       show(got));
          end
        end
        results_seen++;
      end
      if (item.valid && item.ready)
        pending_displays.push_back(predict_display(item.kind, item.hold_count,
                                                   item.adjust_down));
    end
    pending = pending_displays.size();
  end

endmodule

// ----- verif/stopwatch_seven_segment_display_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_seven_segment_display_tb: stimulus and verdict for the stopwatch
// A directed run walks the wrap points, paused ticks, press thresholds and
// the spare kind code; random phases then sweep the threshold and idling.
// ----------------------------------------------------------------------------
module stopwatch_seven_segment_display_tb;

  localparam int ITEMS_PER_PHASE = 255;
  localparam int PHASES = 6;
  localparam int SETTLE_CYCLES = 4;     // margin after the results drain, before a threshold write or the verdict
  localparam int STALL_LIMIT = 5000;    // cycles without any beat before giving up
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         mismatches;
  int         pending;
  int         src_idle_pct;
  int         sink_idle_pct;
  logic [7:0] threshold_now;
  int         quiet_cycles = 0;

  swsd_item_if   item_ch();
  swsd_result_if result_ch();

  stopwatch_seven_segment_display u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  stopwatch_display_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item_ch),
    .result     (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: drop ready at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item and hold it until the beat. Idle gaps come first, so the
  // valid line sees exactly one assignment per edge.
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] hold,
                           input logic down);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= kind;
    item_ch.hold_count  <= hold;
    item_ch.adjust_down <= down;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Hold the item side until every predicted display has come back.
  // Check the count at the falling edge, away from the checker's updates.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write the threshold only once the block has gone quiet.
  task automatic write_threshold(input logic [7:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    threshold_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks and adjust steps so the count moves; presses usually short,
  // since a long one clears the count; the spare kind code now and then.
  task automatic send_random_item(input int down_pct);
    int         pick;
    logic [1:0] kind;
    logic [7:0] hold;
    logic       down;
    pick = $urandom_range(99);
    hold = 8'($urandom_range(255));
    down = 1'($urandom_range(1));
    if (pick < 30) begin
      kind = swsd_pkg::KIND_TICK;
    end else if (pick < 75) begin
      kind = swsd_pkg::KIND_ADJUST;
      down = ($urandom_range(99) < down_pct);
    end else if (pick < 95) begin
      kind = swsd_pkg::KIND_PRESS;
      if ($urandom_range(99) < 85) hold = 8'($urandom_range(threshold_now, 0));
    end else begin
      kind = KIND_SPARE;
    end
    send_beat(kind, hold, down);
  endtask

  initial begin
    logic [7:0] phase_threshold [PHASES];
    phase_threshold = '{8'd255, 8'd0, 8'd0, 8'd1, 8'd0, 8'd254};
    phase_threshold[2] = 8'($urandom_range(2, 253));
    phase_threshold[4] = 8'($urandom_range(2, 253));

    // Hold every block input at a known value from the first instant.
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 8'd0;
    item_ch.valid       <= 1'b0;
    item_ch.kind        <= swsd_pkg::KIND_TICK;
    item_ch.hold_count  <= 8'd0;
    item_ch.adjust_down <= 1'b0;
    src_idle_pct        = 27;
    sink_idle_pct       = 62;
    threshold_now       = swsd_pkg::THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed run at the reset threshold.
    send_beat(swsd_pkg::KIND_TICK,   8'd0,   1'b0);  // running from reset: 00:00:01
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b1);  // back to zero
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b1);  // wrap down to 11:59:59
    send_beat(swsd_pkg::KIND_ADJUST, 8'd255, 1'b0);  // wrap up to zero
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b1);  // 11:59:59 again
    send_beat(swsd_pkg::KIND_TICK,   8'd0,   1'b0);  // tick wraps up
    send_beat(swsd_pkg::KIND_PRESS,  8'd100, 1'b0);  // hold equal to threshold: pause
    send_beat(swsd_pkg::KIND_TICK,   8'd255, 1'b1);  // paused tick: count stays
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b0);  // adjust works while paused
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b1);
    send_beat(swsd_pkg::KIND_ADJUST, 8'd0,   1'b1);  // paused wrap down
    send_beat(KIND_SPARE,            8'd255, 1'b1);  // spare code: only the colon moves
    send_beat(swsd_pkg::KIND_PRESS,  8'd0,   1'b0);  // short press: run
    send_beat(swsd_pkg::KIND_TICK,   8'd0,   1'b0);
    send_beat(swsd_pkg::KIND_TICK,   8'd170, 1'b1);
    send_beat(swsd_pkg::KIND_PRESS,  8'd101, 1'b0);  // just over threshold: clear, pause
    send_beat(swsd_pkg::KIND_PRESS,  8'd255, 1'b1);  // long press while paused
    send_beat(swsd_pkg::KIND_PRESS,  8'd99,  1'b0);  // short press: run
    send_beat(KIND_SPARE,            8'd0,   1'b0);
    send_beat(swsd_pkg::KIND_ADJUST, 8'd255, 1'b0);
    send_beat(swsd_pkg::KIND_PRESS,  8'h55,  1'b1);  // short press: pause
    send_beat(swsd_pkg::KIND_ADJUST, 8'hAA,  1'b1);
    send_beat(swsd_pkg::KIND_TICK,   8'h55,  1'b0);

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          src_idle_pct  = 27;
          sink_idle_pct = 62;
        end
        1: begin
          src_idle_pct  = 62;
          sink_idle_pct = 27;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      write_threshold(phase_threshold[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mid-phase, stop sending until the result side has caught up.
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        // Odd phases lean downward so the count walks back through the minutes.
        send_random_item((phase % 2 == 1) ? 85 : 50);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- stopwatch_seven_segment_display.f -----
src/swsd_pkg.sv
src/swsd_if.sv
src/swsd_clock.sv
src/stopwatch_seven_segment_display.sv
verif/stopwatch_display_checker.sv
verif/stopwatch_seven_segment_display_tb.sv
